@@ sv/jst_pkg.sv @@
// Package for the streaming JSON tokenizer: event record, parse modes,
// event and error codes, literal and escape tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jst_pkg;

   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam logic [6:0] DEPTH_LIMIT_RESET = 7'd64;

   localparam logic [63:0] NUM_TOP   = 64'h8000_0000_0000_0000;
   localparam logic [63:0] NUM_MAXP  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NUM_TENTH = 64'd922337203685477580;

   localparam logic [3:0] EV_OBJ_OPEN  = 4'd0;
   localparam logic [3:0] EV_OBJ_CLOSE = 4'd1;
   localparam logic [3:0] EV_ARR_OPEN  = 4'd2;
   localparam logic [3:0] EV_ARR_CLOSE = 4'd3;
   localparam logic [3:0] EV_STR_START = 4'd4;
   localparam logic [3:0] EV_STR_CHAR  = 4'd5;
   localparam logic [3:0] EV_STR_END   = 4'd6;
   localparam logic [3:0] EV_NUMBER    = 4'd7;
   localparam logic [3:0] EV_NULL      = 4'd8;
   localparam logic [3:0] EV_TRUE      = 4'd9;
   localparam logic [3:0] EV_FALSE     = 4'd10;
   localparam logic [3:0] EV_DONE      = 4'd11;
   localparam logic [3:0] EV_ERROR     = 4'd12;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_UNEXP    = 3'd1;
   localparam logic [2:0] ERR_ESCAPE   = 3'd2;
   localparam logic [2:0] ERR_CODE     = 3'd3;
   localparam logic [2:0] ERR_RANGE    = 3'd4;
   localparam logic [2:0] ERR_DEEP     = 3'd5;
   localparam logic [2:0] ERR_EARLY    = 3'd6;
   localparam logic [2:0] ERR_TRAILING = 3'd7;

   typedef enum logic [3:0] {
      M_TOP, M_ITEM, M_PAIR, M_COLON, M_VALUE, M_AFTER, M_TAIL, M_STR,
      M_ESC, M_HEX, M_SIGN, M_NUM, M_LIT, M_ERR
   } mode_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic        is_key;
      logic [7:0]  ch;
      logic [63:0] num;
      logic [5:0]  nest;
      logic [2:0]  cause;
      logic        last;
   } event_type;

   // up to two events from one byte, in order
   typedef struct packed {
      logic [1:0] cnt;
      event_type  e0;
      event_type  e1;
   } push_type;

   function automatic event_type mk_event(logic [3:0] kind, logic key, logic [7:0] ch,
                                          logic [63:0] num, logic [5:0] nest,
                                          logic [2:0] cause);
      event_type e;
      e.kind   = kind;
      e.is_key = key;
      e.ch     = ch;
      e.num    = num;
      e.nest   = nest;
      e.cause  = cause;
      e.last   = 1'b0;
      return e;
   endfunction

   // "null" "true" "false" back to back
   function automatic logic [7:0] lit_char(logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = "n";
         4'd1:    c = "u";
         4'd2:    c = "l";
         4'd3:    c = "l";
         4'd4:    c = "t";
         4'd5:    c = "r";
         4'd6:    c = "u";
         4'd7:    c = "e";
         4'd8:    c = "f";
         4'd9:    c = "a";
         4'd10:   c = "l";
         4'd11:   c = "s";
         4'd12:   c = "e";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // {hit, decoded byte} for the short escapes
   function automatic logic [8:0] esc_decode(logic [7:0] b);
      logic [8:0] r;
      case (b)
         "\"":    r = {1'b1, 8'h22};
         "\\":    r = {1'b1, 8'h5C};
         "/":     r = {1'b1, 8'h2F};
         "b":     r = {1'b1, 8'h08};
         "f":     r = {1'b1, 8'h0C};
         "n":     r = {1'b1, 8'h0A};
         "r":     r = {1'b1, 8'h0D};
         "t":     r = {1'b1, 8'h09};
         default: r = 9'h000;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ sv/jst_if.sv @@
// Channel interfaces of the tokenizer: byte input, event output, register write.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface jst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   modport source (output valid, output char_byte, input ready);
   modport sink   (input valid, input char_byte, output ready);
endinterface

interface jst_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         event_kind;
   logic               is_key;
   logic [7:0]         char_value;
   logic signed [63:0] number_value;
   logic [5:0]         nest_depth;
   logic [2:0]         error_cause;
   logic               last;
   modport source (output valid, output event_kind, output is_key, output char_value,
                   output number_value, output nest_depth, output error_cause,
                   output last, input ready);
   modport sink   (input valid, input event_kind, input is_key, input char_value,
                   input number_value, input nest_depth, input error_cause,
                   input last, output ready);
endinterface

interface jst_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/jst_core.sv @@
// Tokenizer core: input byte register, parse state, container stack memory,
// one-byte step logic producing up to two events. Depends on jst_pkg, jst_if.
`timescale 1ns / 1ps
`default_nettype none

module jst_core
   import jst_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   jst_req_if.sink         req,
   input  wire logic [6:0] depth_limit,
   input  wire logic       room,
   output push_type        push_out
);

   localparam int NW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = ((NW > 7) ? NW : 7) + 1;

   logic [7:0]    byte_ff;
   logic          vld_ff;
   mode_type      mode_ff, mode_in;
   logic [NW-1:0] nest_ff, nest_in;
   logic [63:0]   mag_ff, mag_in;
   logic          neg_ff, neg_in, ovf_ff, ovf_in;
   logic [15:0]   hex_ff, hex_in;
   logic [2:0]    hcnt_ff, hcnt_in;
   logic [3:0]    lit_ff, lit_in;
   logic          trunc_ff, trunc_in, key_ff, key_in;
   logic          top_ff, below_ff;
   logic          stack_mem [STACK_DEPTH];

   logic          fire;
   logic          push, pop, push_obj;
   logic          pv, sv;
   event_type     pev, sev;
   logic [NW-1:0] nest_m1, nest_m3;

   assign fire      = vld_ff && room;
   assign req.ready = !vld_ff || room;
   assign nest_m1   = nest_ff - NW'(1);
   assign nest_m3   = nest_ff - NW'(3);

   always_comb begin : step
      logic       failing, rearm, do_s, dig, top_obj, pc_do, hexd;
      logic [7:0] b, pc_val, lc;
      logic [3:0] dval, hv, lp;
      logic [2:0] fcause;
      logic [8:0] esc;
      logic [15:0] hacc;
      logic [63:0] prod, lim;
      mode_type   sm;
      logic [5:0] n6, nd6, ni6;
      logic [NW-1:0] nest_dn;

      b        = byte_ff;
      mode_in  = mode_ff;
      nest_in  = nest_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      hex_in   = hex_ff;
      hcnt_in  = hcnt_ff;
      lit_in   = lit_ff;
      trunc_in = trunc_ff;
      key_in   = key_ff;
      push     = 1'b0;
      pop      = 1'b0;
      push_obj = 1'b0;
      pv       = 1'b0;
      sv       = 1'b0;
      pev      = '0;
      sev      = '0;
      failing  = 1'b0;
      fcause   = ERR_NONE;
      rearm    = 1'b0;
      do_s     = 1'b0;
      pc_do    = 1'b0;
      pc_val   = 8'h00;
      sm       = mode_ff;
      dig      = b inside {["0":"9"]};
      dval     = 4'(b - 8'h30);
      top_obj  = (nest_ff != '0) && top_ff;
      n6       = 6'(nest_ff);
      nest_dn  = nest_ff - NW'(1);
      nd6      = 6'(nest_dn);
      ni6      = 6'(nest_ff + NW'(1));
      hexd     = 1'b0;
      hv       = 4'd0;
      hacc     = 16'h0000;
      prod     = 64'd0;
      lim      = neg_ff ? NUM_TOP : NUM_MAXP;
      esc      = esc_decode(b);
      lc       = lit_char(lit_ff);
      lp       = lit_ff + 4'd1;

      case (mode_ff)
         M_SIGN: begin
            if (dig) begin
               mag_in  = 64'(dval);
               mode_in = M_NUM;
            end else begin
               failing = 1'b1;
               fcause  = (b == 8'h00) ? ERR_EARLY : ERR_UNEXP;
            end
         end
         M_NUM: begin
            if (dig) begin
               if (!ovf_ff) begin
                  if (mag_ff > NUM_TENTH) begin
                     ovf_in = 1'b1;
                  end else begin
                     prod   = (mag_ff << 3) + (mag_ff << 1) + 64'(dval);
                     mag_in = prod;
                     if (prod > NUM_TOP) ovf_in = 1'b1;
                  end
               end
            end else if (ovf_ff || mag_ff > lim) begin
               failing = 1'b1;
               fcause  = ERR_RANGE;
            end else begin
               pv   = 1'b1;
               pev  = mk_event(EV_NUMBER, 1'b0, 8'h00, neg_ff ? (64'd0 - mag_ff) : mag_ff,
                               n6, ERR_NONE);
               do_s = 1'b1;
               sm   = (nest_ff == '0) ? M_TAIL : M_AFTER;
            end
         end
         M_STR, M_ESC, M_HEX: begin
            if (b == 8'h00) begin
               failing = 1'b1;
               fcause  = ERR_EARLY;
            end else if (mode_ff == M_STR) begin
               if (b == "\"") begin
                  pv  = 1'b1;
                  pev = mk_event(EV_STR_END, key_ff, 8'h00, 64'd0, n6, ERR_NONE);
                  if (key_ff) begin
                     key_in  = 1'b0;
                     mode_in = M_COLON;
                  end else begin
                     mode_in = (nest_ff == '0) ? M_TAIL : M_AFTER;
                  end
               end else if (b == "\\") begin
                  mode_in = M_ESC;
               end else begin
                  pc_do  = 1'b1;
                  pc_val = b;
               end
            end else if (mode_ff == M_ESC) begin
               if (b == "u") begin
                  hex_in  = 16'h0000;
                  hcnt_in = 3'd0;
                  mode_in = M_HEX;
               end else if (esc[8]) begin
                  pc_do   = 1'b1;
                  pc_val  = esc[7:0];
                  mode_in = M_STR;
               end else begin
                  failing = 1'b1;
                  fcause  = ERR_ESCAPE;
               end
            end else begin
               if (dig) begin
                  hexd = 1'b1;
                  hv   = dval;
               end else if (b inside {["A":"F"]}) begin
                  hexd = 1'b1;
                  hv   = 4'(b - 8'h37);
               end
               if (!hexd) begin
                  failing = 1'b1;
                  fcause  = ERR_ESCAPE;
               end else begin
                  hacc    = {hex_ff[11:0], hv};
                  hex_in  = hacc;
                  hcnt_in = hcnt_ff + 3'd1;
                  if (hcnt_ff >= 3'd3) begin
                     hcnt_in = 3'd0;
                     if (hacc > 16'h00FF) begin
                        failing = 1'b1;
                        fcause  = ERR_CODE;
                     end else begin
                        pc_do   = 1'b1;
                        pc_val  = hacc[7:0];
                        mode_in = M_STR;
                     end
                  end
               end
            end
         end
         M_LIT: begin
            if (b == 8'h00) begin
               failing = 1'b1;
               fcause  = ERR_EARLY;
            end else if (lit_ff < 4'd13 && b == lc) begin
               if (lp == 4'd4 || lp == 4'd8 || lp == 4'd13) begin
                  pv      = 1'b1;
                  pev     = mk_event((lp == 4'd4) ? EV_NULL : (lp == 4'd8) ? EV_TRUE : EV_FALSE,
                                     1'b0, 8'h00, 64'd0, n6, ERR_NONE);
                  lit_in  = 4'd0;
                  mode_in = (nest_ff == '0) ? M_TAIL : M_AFTER;
               end else begin
                  lit_in = lp;
               end
            end else begin
               failing = 1'b1;
               fcause  = ERR_UNEXP;
            end
         end
         M_ERR: begin
            if (b == 8'h00) rearm = 1'b1;
         end
         default: begin
            do_s = 1'b1;
         end
      endcase

      if (pc_do) begin
         if (pc_val == 8'h00) begin
            trunc_in = 1'b1;
         end else if (!trunc_ff) begin
            pv  = 1'b1;
            pev = mk_event(EV_STR_CHAR, key_ff, pc_val, 64'd0, n6, ERR_NONE);
         end
      end

      if (failing) begin
         pv  = 1'b1;
         pev = mk_event(EV_ERROR, 1'b0, 8'h00, 64'd0, n6, fcause);
      end

      // byte handled between values; after a number, in the mode the number left
      if (do_s) begin
         mode_in = sm;
         if (b == 8'h00) begin
            if (sm == M_TAIL) begin
               sv    = 1'b1;
               sev   = mk_event(EV_DONE, 1'b0, 8'h00, 64'd0, n6, ERR_NONE);
               rearm = 1'b1;
            end else begin
               failing = 1'b1;
               fcause  = ERR_EARLY;
            end
         end else if (!(b inside {8'h20, 8'h09, 8'h0D, 8'h0A})) begin
            if ((sm == M_ITEM && b == "]") || (sm == M_PAIR && b == "}") ||
                (sm == M_AFTER && ((b == "}" && top_obj) || (b == "]" && !top_obj)))) begin
               pop     = 1'b1;
               nest_in = nest_dn;
               sv      = 1'b1;
               sev     = mk_event(top_obj ? EV_OBJ_CLOSE : EV_ARR_CLOSE, 1'b0, 8'h00, 64'd0,
                                  nd6, ERR_NONE);
               mode_in = (nest_dn == '0) ? M_TAIL : M_AFTER;
            end else if (sm == M_TOP || sm == M_VALUE || sm == M_ITEM) begin
               if (b == "\"") begin
                  key_in   = 1'b0;
                  trunc_in = 1'b0;
                  sv       = 1'b1;
                  sev      = mk_event(EV_STR_START, 1'b0, 8'h00, 64'd0, n6, ERR_NONE);
                  mode_in  = M_STR;
               end else if (b == "{" || b == "[") begin
                  if (CW'(nest_ff) + CW'(1) >= CW'(depth_limit) ||
                      nest_ff >= NW'(STACK_DEPTH)) begin
                     failing = 1'b1;
                     fcause  = ERR_DEEP;
                  end else begin
                     push     = 1'b1;
                     push_obj = (b == "{");
                     nest_in  = nest_ff + NW'(1);
                     sv       = 1'b1;
                     sev      = mk_event((b == "{") ? EV_OBJ_OPEN : EV_ARR_OPEN, 1'b0, 8'h00,
                                         64'd0, ni6, ERR_NONE);
                     mode_in  = (b == "{") ? M_PAIR : M_ITEM;
                  end
               end else if (dig) begin
                  neg_in  = 1'b0;
                  ovf_in  = 1'b0;
                  mag_in  = 64'(dval);
                  mode_in = M_NUM;
               end else if (b == "-") begin
                  neg_in  = 1'b1;
                  ovf_in  = 1'b0;
                  mag_in  = 64'd0;
                  mode_in = M_SIGN;
               end else if (b == "n" || b == "t" || b == "f") begin
                  lit_in  = (b == "n") ? 4'd1 : (b == "t") ? 4'd5 : 4'd9;
                  mode_in = M_LIT;
               end else begin
                  failing = 1'b1;
                  fcause  = ERR_UNEXP;
               end
            end else if (sm == M_PAIR && b == "\"") begin
               key_in   = 1'b1;
               trunc_in = 1'b0;
               sv       = 1'b1;
               sev      = mk_event(EV_STR_START, 1'b1, 8'h00, 64'd0, n6, ERR_NONE);
               mode_in  = M_STR;
            end else if (sm == M_COLON && b == ":") begin
               mode_in = M_VALUE;
            end else if (sm == M_AFTER && b == ",") begin
               mode_in = top_obj ? M_PAIR : M_ITEM;
            end else begin
               failing = 1'b1;
               fcause  = (sm == M_TAIL) ? ERR_TRAILING : ERR_UNEXP;
            end
         end
         if (failing) begin
            sv  = 1'b1;
            sev = mk_event(EV_ERROR, 1'b0, 8'h00, 64'd0, n6, fcause);
         end
      end

      if (failing) begin
         if (b == 8'h00) rearm = 1'b1;
         else mode_in = M_ERR;
      end

      if (rearm) begin
         mode_in  = M_TOP;
         nest_in  = '0;
         mag_in   = 64'd0;
         neg_in   = 1'b0;
         ovf_in   = 1'b0;
         hex_in   = 16'h0000;
         hcnt_in  = 3'd0;
         lit_in   = 4'd0;
         trunc_in = 1'b0;
         key_in   = 1'b0;
      end
   end

   always_comb begin
      push_out = '0;
      if (fire) begin
         if (pv && sv) begin
            push_out.cnt     = 2'd2;
            push_out.e0      = pev;
            push_out.e1      = sev;
            push_out.e1.last = 1'b1;
         end else if (pv || sv) begin
            push_out.cnt     = 2'd1;
            push_out.e0      = pv ? pev : sev;
            push_out.e0.last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= 1'b0;
         mode_ff  <= M_TOP;
         nest_ff  <= '0;
         mag_ff   <= 64'd0;
         neg_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
         hex_ff   <= 16'h0000;
         hcnt_ff  <= 3'd0;
         lit_ff   <= 4'd0;
         trunc_ff <= 1'b0;
         key_ff   <= 1'b0;
      end else begin
         if (req.valid && req.ready) vld_ff <= 1'b1;
         else if (fire) vld_ff <= 1'b0;
         if (fire) begin
            mode_ff  <= mode_in;
            nest_ff  <= nest_in;
            mag_ff   <= mag_in;
            neg_ff   <= neg_in;
            ovf_ff   <= ovf_in;
            hex_ff   <= hex_in;
            hcnt_ff  <= hcnt_in;
            lit_ff   <= lit_in;
            trunc_ff <= trunc_in;
            key_ff   <= key_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) byte_ff <= req.char_byte;
   end

   // top entry and the one below live in flops; the rest spills to memory
   always_ff @(posedge clock) begin
      if (fire && push) begin
         if (nest_ff != '0) stack_mem[nest_m1[AW-1:0]] <= top_ff;
         top_ff   <= push_obj;
         below_ff <= top_ff;
      end else if (fire && pop) begin
         top_ff   <= below_ff;
         below_ff <= stack_mem[nest_m3[AW-1:0]];
      end
   end

   a_two_events_after_number: assert property (@(posedge clock) disable iff (reset)
      push_out.cnt == 2'd2 |-> push_out.e0.kind == EV_NUMBER)
      else $error("second event without a number event first");

   a_error_mode_silent: assert property (@(posedge clock) disable iff (reset)
      fire && mode_ff == M_ERR |-> push_out.cnt == 2'd0)
      else $error("event emitted while waiting for end of text");

   a_nest_bound: assert property (@(posedge clock) disable iff (reset)
      nest_ff <= NW'(STACK_DEPTH))
      else $error("nesting count beyond stack depth");

   a_no_fire_no_change: assert property (@(posedge clock) disable iff (reset)
      !$past(fire) && !$past(reset) |-> $stable(nest_ff))
      else $error("nesting changed without a byte processed");

endmodule

`default_nettype wire

@@ sv/jst_fifo.sv @@
// Four-entry event queue: takes up to two events a cycle while it has room, delivers one while the output is ready.
// Depends on jst_pkg, jst_if.
`timescale 1ns / 1ps
`default_nettype none

module jst_fifo
   import jst_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  push_type  push_in,
   output logic      room,
   jst_rsp_if.source rsp
);

   event_type  slot_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff;
   logic       pop;
   event_type  head;

   assign pop  = rsp.valid && rsp.ready;
   assign room = cnt_ff <= 3'd2;
   assign head = slot_ff[rd_ff];

   assign rsp.valid        = cnt_ff != 3'd0;
   assign rsp.event_kind   = head.kind;
   assign rsp.is_key       = head.is_key;
   assign rsp.char_value   = head.ch;
   assign rsp.number_value = head.num;
   assign rsp.nest_depth   = head.nest;
   assign rsp.error_cause  = head.cause;
   assign rsp.last         = head.last;

   always_ff @(posedge clock) begin
      if (push_in.cnt != 2'd0) slot_ff[wr_ff] <= push_in.e0;
      if (push_in.cnt == 2'd2) slot_ff[wr_ff + 2'd1] <= push_in.e1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 2'd0;
         rd_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         wr_ff  <= wr_ff + push_in.cnt;
         rd_ff  <= rd_ff + {1'b0, pop};
         cnt_ff <= cnt_ff + {1'b0, push_in.cnt} - {2'b00, pop};
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4)
      else $error("event queue overflow");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      push_in.cnt != 2'd0 |-> room)
      else $error("events pushed without room");

   a_last_on_tail: assert property (@(posedge clock) disable iff (reset)
      push_in.cnt == 2'd2 |-> !push_in.e0.last && push_in.e1.last)
      else $error("last flag misplaced on event pair");

endmodule

`default_nettype wire

@@ sv/json_stream_tokenizer.sv @@
// Top level of the streaming JSON tokenizer: depth limit register, core, queue.
// Depends on jst_pkg, jst_if, jst_core, jst_fifo.
//
//   channel   dir  payload                                   transaction
//   req_chan  in   char_byte                                 one document byte
//   rsp_chan  out  event_kind..last                          one parse event
//   csr_chan  in   data (depth_limit)                        register write
//
// One byte per cycle while the queue has room; the byte is registered,
// stepped, and its zero to two events enter a four-entry queue. A byte
// that makes two events fills the queue faster than one event per cycle
// drains it, so the queue occupancy sets the sustained rate then.
// Reset is synchronous; it clears parse state, depth_limit goes to 64.
// Stack entries are not cleared; only entries below the nesting count are read.
`timescale 1ns / 1ps
`default_nettype none

module json_stream_tokenizer
   import jst_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   jst_req_if.sink   req_chan,
   jst_rsp_if.source rsp_chan,
   jst_csr_if.sink   csr_chan
);

   logic [6:0] depth_limit_ff;
   logic       room;
   push_type   push_ev;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_limit_ff <= DEPTH_LIMIT_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         depth_limit_ff <= csr_chan.data;
      end
   end

   jst_core #(.STACK_DEPTH(STACK_DEPTH)) u_core (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .depth_limit (depth_limit_ff),
      .room        (room),
      .push_out    (push_ev)
   );

   jst_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push_in (push_ev),
      .room    (room),
      .rsp     (rsp_chan)
   );

endmodule

`default_nettype wire
